>>> design/jddc_pkg.sv
`default_nettype none
package jddc_pkg;

  typedef enum logic {
    MODE_TO_JDN  = 1'b0,
    MODE_TO_DATE = 1'b1
  } mode_t;

  // Bias values that make the cycle numerators non-negative
  localparam logic signed [31:0] YearNumBias  = 32'sd1051860;   // 2820 * 373
  localparam logic signed [31:0] JdnNumBias   = 32'sd537589646; // 1029983 * 524 - epoch
  localparam logic [10:0]        YearCycBias  = 11'd373;
  localparam logic [10:0]        JdnCycBias   = 11'd524;
  localparam logic signed [31:0] BaseYearPos  = 32'sd475;
  localparam logic signed [31:0] BaseYearNeg  = 32'sd474;
  localparam logic signed [31:0] EpochJdn     = 32'sd2121446;
  localparam logic [20:0]        CycleDays    = 21'd1029983;
  localparam logic [20:0]        CycleYears   = 21'd2820;
  localparam logic [9:0]         LeapNum      = 10'd683;
  localparam logic [8:0]         YearDays     = 9'd365;

  // Reciprocals for the constant dividers: floor(2^S / D)
  localparam logic [11:0] RecipYears21 = 12'd743;   // 2^21 / 2820
  localparam logic [11:0] RecipDays31  = 12'd2084;  // 2^31 / 1029983
  localparam logic [12:0] RecipDays32  = 13'd4169;  // 2^32 / 1029983

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef struct packed {
    mode_t       mode;
    logic [30:0] num;
    logic [8:0]  diy;
    logic        date_ok;
    logic        need_leap;
  } jddc_entry_t;

  typedef struct packed {
    logic        vld;
    mode_t       mode;
    logic [8:0]  diy;
    logic        date_ok;
    logic        need_leap;
  } jddc_meta_t;

  // Days in the year before the first day of month m
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd62;
      4'd4:    r = 9'd93;
      4'd5:    r = 9'd124;
      4'd6:    r = 9'd155;
      4'd7:    r = 9'd186;
      4'd8:    r = 9'd216;
      4'd9:    r = 9'd246;
      4'd10:   r = 9'd276;
      4'd11:   r = 9'd306;
      4'd12:   r = 9'd336;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/jddc_front.sv
`default_nettype none
module jddc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic signed [20:0]    in_year_in,
  input  wire logic [3:0]            in_month_in,
  input  wire logic [4:0]            in_day_in,
  input  wire logic signed [29:0]    in_jdn_in,
  output logic                       ent_valid,
  output jddc_pkg::jddc_entry_t      ent,
  input  wire logic                  ent_ready
);
  import jddc_pkg::*;

  logic               v_r;
  logic               mode_r;
  logic signed [20:0] year_r;
  logic [3:0]         month_r;
  logic [4:0]         day_r;
  logic signed [29:0] jdn_r;

  assign in_stall  = v_r & ~ent_ready;
  assign ent_valid = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!in_stall) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r  <= in_mode;
      year_r  <= in_year_in;
      month_r <= in_month_in;
      day_r   <= in_day_in;
      jdn_r   <= in_jdn_in;
    end
  end

  always_comb begin
    logic signed [31:0] year_x;
    logic signed [31:0] ynum;
    logic signed [31:0] jnum;
    logic               month_ok;
    logic               day_ok;
    year_x   = {{11{year_r[20]}}, year_r};
    ynum     = year_x - (year_r[20] ? BaseYearNeg : BaseYearPos) + YearNumBias;
    jnum     = {{2{jdn_r[29]}}, jdn_r} + JdnNumBias;
    month_ok = month_r inside {[4'd1:4'd12]};
    // month 12 allows day 30 here; the leap test later settles it
    day_ok   = (day_r != 5'd0) && (day_r <= ((month_r < 4'd7) ? 5'd31 : 5'd30));
    ent.mode      = mode_t'(mode_r);
    ent.num       = (mode_r == MODE_TO_DATE) ? jnum[30:0] : ynum[30:0];
    ent.diy       = month_offset(month_r) + {4'b0, day_r};
    ent.date_ok   = (year_r != 21'sd0) && month_ok && day_ok;
    ent.need_leap = (month_r == 4'd12) && (day_r == 5'd30);
  end

endmodule
`default_nettype wire

>>> design/jddc_fifo.sv
`default_nettype none
module jddc_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_valid,
  input  wire jddc_pkg::jddc_entry_t push_data,
  output logic                       push_ready,
  input  wire logic                  pop,
  output logic                       pop_valid,
  output jddc_pkg::jddc_entry_t      pop_data
);
  import jddc_pkg::*;

  jddc_entry_t      mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   count_r;
  logic             push;
  logic             do_pop;

  assign push_ready = (count_r != (QPtrW+1)'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/jddc_back.sv
`default_nettype none
module jddc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pop_valid,
  input  wire jddc_pkg::jddc_entry_t pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_valid_res,
  output logic signed [29:0]         out_jdn_out,
  output logic signed [20:0]         out_year_out,
  output logic [3:0]                 out_month_out,
  output logic [4:0]                 out_day_out
);
  import jddc_pkg::*;

  logic en;
  jddc_meta_t meta_r [1:9];

  // stage registers
  logic [10:0] qe1_r;
  logic [30:0] num1_r;
  logic [10:0] cyc2_r;
  logic [19:0] rem2_r;
  logic [31:0] x3_r;
  logic [10:0] cyc3_r;
  logic [19:0] rem3_r;
  logic [11:0] qe4_r;
  logic [31:0] x4_r;
  logic [10:0] cyc4_r;
  logic [19:0] rem4_r;
  logic [11:0] yic5_r;
  logic [10:0] cyc5_r;
  logic [19:0] rem5_r;
  logic [20:0] a06_r, a16_r;
  logic signed [31:0] cterm6_r;
  logic [11:0] yic6_r;
  logic [19:0] rem6_r;
  logic [9:0]  qf07_r, qf17_r;
  logic [20:0] a07_r, a17_r;
  logic signed [31:0] cterm7_r;
  logic [11:0] yic7_r;
  logic [19:0] rem7_r;
  logic [9:0]  f08_r, f18_r;
  logic signed [31:0] cterm8_r;
  logic [11:0] yic8_r;
  logic [19:0] rem8_r;
  logic [29:0] jdn9_r;
  logic [8:0]  d9_r;
  logic signed [22:0] yr9_r;
  logic        leap9_r;
  logic        v09_r;

  logic              out_valid_r;
  logic              valid_res_r;
  logic [29:0]       jdn_out_r;
  logic [20:0]       year_out_r;
  logic [3:0]        month_out_r;
  logic [4:0]        day_out_r;

  // whole pipe moves together while the output slot can take a new item
  assign en  = ~out_valid_r | ~out_stall;
  assign pop = en & pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 9; i++) begin
        meta_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      meta_r[1].vld       <= pop_valid;
      meta_r[1].mode      <= pop_data.mode;
      meta_r[1].diy       <= pop_data.diy;
      meta_r[1].date_ok   <= pop_data.date_ok;
      meta_r[1].need_leap <= pop_data.need_leap;
      for (int i = 2; i <= 9; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // stage 1: quotient estimate of the cycle split
  logic [42:0] prod1;
  assign prod1 = {12'b0, pop_data.num} *
                 {31'b0, ((pop_data.mode == MODE_TO_DATE) ? RecipDays31 : RecipYears21)};

  always_ff @(posedge clk) begin
    if (en) begin
      qe1_r  <= (pop_data.mode == MODE_TO_DATE) ? prod1[41:31] : prod1[31:21];
      num1_r <= pop_data.num;
    end
  end

  // stage 2: remainder and one correction step
  logic [20:0] div2;
  logic [31:0] qd2;
  logic [31:0] r2_raw;
  logic [20:0] r2;
  logic [10:0] q2;
  logic [19:0] rem2_c;
  logic [10:0] cyc2_c;
  always_comb begin
    div2   = (meta_r[1].mode == MODE_TO_DATE) ? CycleDays : CycleYears;
    qd2    = {21'b0, qe1_r} * {11'b0, div2};
    r2_raw = {1'b0, num1_r} - qd2;
    r2     = r2_raw[20:0];
    if (r2 >= div2) begin
      q2     = qe1_r + 11'd1;
      rem2_c = 20'(r2 - div2);
    end else begin
      q2     = qe1_r;
      rem2_c = r2[19:0];
    end
    cyc2_c = q2 - ((meta_r[1].mode == MODE_TO_DATE) ? JdnCycBias : YearCycBias);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyc2_r <= cyc2_c;
      rem2_r <= rem2_c;
    end
  end

  // stage 3: scale the cycle remainder (the day offset when converting to a date) by years per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      x3_r   <= {12'b0, rem2_r} * {20'b0, CycleYears[11:0]};
      cyc3_r <= cyc2_r;
      rem3_r <= rem2_r;
    end
  end

  // stage 4: year-in-cycle estimate
  logic [44:0] prod4;
  assign prod4 = {13'b0, x3_r} * {32'b0, RecipDays32};

  always_ff @(posedge clk) begin
    if (en) begin
      qe4_r  <= prod4[43:32];
      x4_r   <= x3_r;
      cyc4_r <= cyc3_r;
      rem4_r <= rem3_r;
    end
  end

  // stage 5: correct the year-in-cycle
  logic [31:0] r5_raw;
  logic [20:0] r5;
  logic [11:0] q5;
  always_comb begin
    r5_raw = x4_r - ({20'b0, qe4_r} * {11'b0, CycleDays});
    r5     = r5_raw[20:0];
    q5     = (r5 >= CycleDays) ? qe4_r + 12'd1 : qe4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yic5_r <= (meta_r[4].mode == MODE_TO_DATE) ? q5 : rem4_r[11:0];
      cyc5_r <= cyc4_r;
      rem5_r <= rem4_r;
    end
  end

  // stage 6: leap numerators for this and the next year, cycle term
  logic signed [31:0] cyc6_x;
  assign cyc6_x = {{21{cyc5_r[10]}}, cyc5_r};

  always_ff @(posedge clk) begin
    if (en) begin
      a06_r    <= 21'({9'b0, yic5_r} * {11'b0, LeapNum});
      a16_r    <= 21'(({9'b0, yic5_r} + 21'd1) * {11'b0, LeapNum});
      cterm6_r <= cyc6_x * ((meta_r[5].mode == MODE_TO_DATE) ?
                            32'sd2820 : 32'sd1029983);
      yic6_r   <= yic5_r;
      rem6_r   <= rem5_r;
    end
  end

  // stage 7: divide both numerators by years per cycle
  logic [32:0] p70, p71;
  assign p70 = {12'b0, a06_r} * {21'b0, RecipYears21};
  assign p71 = {12'b0, a16_r} * {21'b0, RecipYears21};

  always_ff @(posedge clk) begin
    if (en) begin
      qf07_r   <= p70[30:21];
      qf17_r   <= p71[30:21];
      a07_r    <= a06_r;
      a17_r    <= a16_r;
      cterm7_r <= cterm6_r;
      yic7_r   <= yic6_r;
      rem7_r   <= rem6_r;
    end
  end

  // stage 8: correct both quotients
  logic [21:0] r80, r81;
  always_comb begin
    r80 = 22'({1'b0, a07_r} - ({12'b0, qf07_r} * {1'b0, CycleYears}));
    r81 = 22'({1'b0, a17_r} - ({12'b0, qf17_r} * {1'b0, CycleYears}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f08_r    <= (r80 >= {1'b0, CycleYears}) ? qf07_r + 10'd1 : qf07_r;
      f18_r    <= (r81 >= {1'b0, CycleYears}) ? qf17_r + 10'd1 : qf17_r;
      cterm8_r <= cterm7_r;
      yic8_r   <= yic7_r;
      rem8_r   <= rem7_r;
    end
  end

  // stage 9: year start, day number, day of year, year
  logic [20:0]        fy9;
  logic signed [31:0] jdn9_c;
  logic [20:0]        d9_c;
  logic signed [31:0] yr9_c;
  always_comb begin
    fy9    = 21'({9'b0, yic8_r} * {12'b0, YearDays}) + {11'b0, f08_r};
    jdn9_c = EpochJdn + cterm8_r + $signed({11'b0, fy9}) +
             $signed({23'b0, meta_r[8].diy}) - 32'sd1;
    d9_c   = {1'b0, rem8_r} + 21'd1 - fy9;
    yr9_c  = cterm8_r + $signed({20'b0, yic8_r}) + BaseYearPos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jdn9_r  <= jdn9_c[29:0];
      d9_r    <= d9_c[8:0];
      yr9_r   <= yr9_c[22:0];
      leap9_r <= (f18_r != f08_r);
      v09_r   <= meta_r[8].date_ok & (~meta_r[8].need_leap | (f18_r != f08_r));
    end
  end

  // stage 10: year overflow, skip year zero, month walk
  logic [8:0]         ylen;
  logic signed [22:0] yr_a, yr_b;
  logic [8:0]         d_f;
  logic [3:0]         mon;
  logic [8:0]         dom;
  logic               fits;
  always_comb begin
    ylen = leap9_r ? 9'd366 : 9'd365;
    if (d9_r > ylen) begin
      yr_a = yr9_r + 23'sd1;
      d_f  = 9'd1;
    end else begin
      yr_a = yr9_r;
      d_f  = d9_r;
    end
    yr_b = (yr_a <= 23'sd0) ? yr_a - 23'sd1 : yr_a;
    mon  = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (d_f > month_offset(4'(k))) begin
        mon = mon + 4'd1;
      end
    end
    dom  = d_f - month_offset(mon);
    fits = (yr_b >= -23'sd1048576) && (yr_b <= 23'sd1048575);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= meta_r[9].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (meta_r[9].mode == MODE_TO_DATE) begin
        valid_res_r <= fits;
        jdn_out_r   <= '0;
        year_out_r  <= yr_b[20:0];
        month_out_r <= mon;
        day_out_r   <= dom[4:0];
      end else begin
        valid_res_r <= v09_r;
        jdn_out_r   <= v09_r ? jdn9_r : '0;
        year_out_r  <= '0;
        month_out_r <= '0;
        day_out_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = valid_res_r;
  assign out_jdn_out   = $signed(jdn_out_r);
  assign out_year_out  = $signed(year_out_r);
  assign out_month_out = month_out_r;
  assign out_day_out   = day_out_r;

endmodule
`default_nettype wire

>>> design/jalali_date_julian_day_convert.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | mode, year_in, month_in, day_in, jdn_in
// out_    | output    | out_valid / out_stall | valid_res, jdn_out, year_out, month_out, day_out
//
// One item per cycle sustained while out_ is not stalled. The path runs through the input
// register, the queue, nine back-end stages and the output register.
// The rate is set by the back-end pipeline, which advances whenever the output
// register is empty or being taken; the four-entry queue absorbs front-end items.
// Synchronous active-low reset empties the input register, queue and pipeline.
// A stall on out_ holds the back end; in_stall rises only once the queue is full.
`default_nettype none
module jalali_date_julian_day_convert (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [20:0] in_year_in,
  input  wire logic [3:0]         in_month_in,
  input  wire logic [4:0]         in_day_in,
  input  wire logic signed [29:0] in_jdn_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_valid_res,
  output logic signed [29:0]      out_jdn_out,
  output logic signed [20:0]      out_year_out,
  output logic [3:0]              out_month_out,
  output logic [4:0]              out_day_out
);
  import jddc_pkg::*;

  logic        ent_valid;
  logic        ent_ready;
  jddc_entry_t ent;
  logic        pop_valid;
  logic        pop;
  jddc_entry_t pop_data;

  jddc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_year_in  (in_year_in),
    .in_month_in (in_month_in),
    .in_day_in   (in_day_in),
    .in_jdn_in   (in_jdn_in),
    .ent_valid   (ent_valid),
    .ent         (ent),
    .ent_ready   (ent_ready)
  );

  jddc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (ent_valid),
    .push_data  (ent),
    .push_ready (ent_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  jddc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_jdn_out   (out_jdn_out),
    .out_year_out  (out_year_out),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out)
  );

endmodule
`default_nettype wire

>>> design/jddc_checker.sv
`default_nettype none
module jddc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_valid_res,
  input wire logic signed [29:0] out_jdn_out,
  input wire logic signed [20:0] out_year_out,
  input wire logic [3:0]         out_month_out,
  input wire logic [4:0]         out_day_out
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_jdn_out) && $stable(out_year_out))
    else $error("result changed under stall");

  // a date result has a real month and day and no year zero; otherwise all zero
  a_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_out == 21'sd0 && out_month_out == 4'd0 && out_day_out == 5'd0) ||
                  (out_year_out != 21'sd0 && out_month_out >= 4'd1 &&
                   out_month_out <= 4'd12 && out_day_out >= 5'd1))
    else $error("malformed date result");

  // a day number is only given for a valid date
  a_jdn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jdn_out != 30'sd0 |-> out_valid_res && out_month_out == 4'd0)
    else $error("day number without valid date");

  // reset empties the output
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind jalali_date_julian_day_convert jddc_checker u_jddc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_valid_res (out_valid_res),
  .out_jdn_out   (out_jdn_out),
  .out_year_out  (out_year_out),
  .out_month_out (out_month_out),
  .out_day_out   (out_day_out)
);
`default_nettype wire
